// ----- rtl/thrl_pkg.sv -----
// ----------------------------------------------------------------------------
// thrl_pkg
// shared types, codes and helpers for the text hex record loader
// ----------------------------------------------------------------------------
package thrl_pkg;

    // input operation codes
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_EOL  = 2'd1;
    localparam logic [1:0] OP_EOF  = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // line layout
    localparam int NUM_PAIRS = 10;
    localparam logic [4:0] COL_DATA = 5'd7;
    localparam logic [4:0] COL_LAST_DATA = 5'd26;
    localparam logic [4:0] COL_PARITY_ONLY = 5'd27;
    localparam logic [4:0] COL_BAR = 5'd28;
    localparam logic [4:0] COL_SAT = 5'd29;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    localparam int LINE_COUNT_BITS_DEF = 16;
    localparam int LINE_NUM_W = 16;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] line_number;
        logic        load_ok;
        logic        last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic take_char;
        logic end_line;
        logic end_file;
        logic emit;
        logic busy;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic will_emit;
        logic emit_last;
        logic halted;
    } t_ctl_sts;

    // {valid, value} of an ascii hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, ch[3:0]};
        end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
            r = {1'b1, ch[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ----- rtl/thrl_ctrl.sv -----
// ----------------------------------------------------------------------------
// thrl_ctrl
// sequencer: takes input items and drains byte writes at line end
// ----------------------------------------------------------------------------
module thrl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_op,
    output logic                o_in_ready,
    input  thrl_pkg::t_ctl_sts  i_sts,
    output thrl_pkg::t_ctl_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    // items that never produce a result need no free output slot
    assign o_in_ready = (r_state == S_IDLE) &&
                        (i_sts.out_free || i_op == thrl_pkg::OP_CHAR ||
                         i_op == thrl_pkg::OP_NOP);
    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.take_char = w_accept && (i_op == thrl_pkg::OP_CHAR);
        o_cmd.end_line  = w_accept && (i_op == thrl_pkg::OP_EOL);
        o_cmd.end_file  = w_accept && (i_op == thrl_pkg::OP_EOF);
        o_cmd.emit      = (r_state == S_EMIT) && i_sts.out_free;
        o_cmd.busy      = (r_state == S_EMIT);
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.end_line && i_sts.will_emit) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_cmd.emit && i_sts.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/thrl_datapath.sv -----
// ----------------------------------------------------------------------------
// thrl_datapath
// line parser, pair store, line counter and output register
// ----------------------------------------------------------------------------
module thrl_datapath #(
    parameter int LINE_COUNT_BITS = thrl_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_char,
    input  thrl_pkg::t_ctl_cmd  i_cmd,
    output thrl_pkg::t_ctl_sts  o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output thrl_pkg::t_out_item o_out_item
);

    localparam int PW = $clog2(thrl_pkg::NUM_PAIRS);

    logic [4:0]                      r_column;
    logic [11:0]                     r_line_address;
    logic [7:0]                      r_pair_bytes [thrl_pkg::NUM_PAIRS];
    logic [thrl_pkg::NUM_PAIRS-1:0]  r_pair_present;
    logic                            r_line_bad;
    logic                            r_first_blank;
    logic                            r_parity;
    logic [LINE_COUNT_BITS-1:0]      r_lines_seen;
    logic                            r_halted;
    logic [3:0]                      r_hi_nib;
    logic                            r_out_valid;
    thrl_pkg::t_out_item             r_out_item;

    logic [4:0]                      w_hex;
    logic                            w_is_hex;
    logic [3:0]                      w_hex_val;
    logic                            w_blank;
    logic [4:0]                      w_off;
    logic [PW-1:0]                   w_pidx;
    logic                            w_line_err;
    logic [PW-1:0]                   w_emit_idx;
    logic [thrl_pkg::NUM_PAIRS-1:0]  w_emit_bit;
    logic [15:0]                     w_line_num;
    logic                            w_char_live;
    logic                            w_out_load;

    assign w_hex     = thrl_pkg::hex_decode(i_char);
    assign w_is_hex  = w_hex[4];
    assign w_hex_val = w_hex[3:0];
    assign w_blank   = (i_char == thrl_pkg::CH_SPACE);
    assign w_off     = r_column - thrl_pkg::COL_DATA;
    assign w_pidx    = w_off[PW:1];
    assign w_char_live = i_cmd.take_char && !r_halted && (r_column < thrl_pkg::COL_SAT);

    assign w_line_err = !r_first_blank &&
                        (r_line_bad || (r_column < thrl_pkg::COL_SAT) || r_parity);

    // a new result enters the output register
    assign w_out_load = (i_cmd.end_line && !r_halted && w_line_err) || i_cmd.end_file ||
                        i_cmd.emit;

    // lowest pending pair
    always_comb begin
        w_emit_idx = '0;
        for (int i = thrl_pkg::NUM_PAIRS - 1; i >= 0; i--) begin
            if (r_pair_present[i]) begin
                w_emit_idx = PW'(i);
            end
        end
        w_emit_bit = '0;
        w_emit_bit[w_emit_idx] = 1'b1;
    end

    generate
        if (LINE_COUNT_BITS > 16) begin : g_sat
            assign w_line_num = (|r_lines_seen[LINE_COUNT_BITS-1:16]) ? 16'hFFFF
                                                                      : r_lines_seen[15:0];
        end else begin : g_ext
            assign w_line_num = 16'(r_lines_seen);
        end
    endgenerate

    always_comb begin
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.will_emit = !r_halted && !w_line_err && r_pair_present[0];
        o_sts.emit_last = ((r_pair_present & ~w_emit_bit) == '0);
        o_sts.halted    = r_halted;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column       <= '0;
            r_line_address <= '0;
            r_pair_present <= '0;
            r_line_bad     <= 1'b0;
            r_first_blank  <= 1'b0;
            r_parity       <= 1'b0;
            r_lines_seen   <= LINE_COUNT_BITS'(1);
            r_halted       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_char_live) begin
                r_column <= r_column + 5'd1;
                priority if (r_column == 5'd0) begin
                    r_first_blank <= w_blank;
                    if (i_char != thrl_pkg::CH_ZERO) r_line_bad <= 1'b1;
                end else if (r_column == 5'd1) begin
                    if (i_char != thrl_pkg::CH_X) r_line_bad <= 1'b1;
                end else if (r_column <= 5'd4) begin
                    if (!w_is_hex) r_line_bad <= 1'b1;
                    r_line_address <= {r_line_address[7:0], w_is_hex ? w_hex_val : 4'd0};
                end else if (r_column == 5'd5) begin
                    if (i_char != thrl_pkg::CH_COLON) r_line_bad <= 1'b1;
                end else if (r_column == 5'd6) begin
                    if (i_char != thrl_pkg::CH_SPACE) r_line_bad <= 1'b1;
                end else if (r_column <= thrl_pkg::COL_LAST_DATA) begin
                    if (!w_blank) begin
                        r_parity <= ~r_parity;
                        if (!w_is_hex) r_line_bad <= 1'b1;
                        if (!w_off[0]) r_pair_present[w_pidx] <= 1'b1;
                    end
                end else if (r_column == thrl_pkg::COL_PARITY_ONLY) begin
                    if (!w_blank) r_parity <= ~r_parity;
                end else begin
                    if (i_char != thrl_pkg::CH_BAR) r_line_bad <= 1'b1;
                end
            end
            if (i_cmd.end_line && !r_halted) begin
                if (w_line_err) begin
                    r_halted    <= 1'b1;
                end
                if (r_lines_seen != {LINE_COUNT_BITS{1'b1}}) begin
                    r_lines_seen <= r_lines_seen + LINE_COUNT_BITS'(1);
                end
                r_column      <= '0;
                r_line_bad    <= 1'b0;
                r_first_blank <= 1'b0;
                r_parity      <= 1'b0;
                // line address and pair flags stay for the write drain
                if (!o_sts.will_emit) begin
                    r_line_address <= '0;
                    r_pair_present <= '0;
                end
            end
            if (i_cmd.end_file) begin
                r_column       <= '0;
                r_line_address <= '0;
                r_pair_present <= '0;
                r_line_bad     <= 1'b0;
                r_first_blank  <= 1'b0;
                r_parity       <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_pair_present <= r_pair_present & ~w_emit_bit;
                if (o_sts.emit_last) r_line_address <= '0;
            end
        end
    end

    // pair bytes and output payload
    always_ff @(posedge i_clk) begin
        if (w_char_live && r_column >= thrl_pkg::COL_DATA &&
            r_column <= thrl_pkg::COL_LAST_DATA) begin
            if (!w_off[0]) begin
                r_hi_nib <= w_is_hex ? w_hex_val : 4'd0;
                r_pair_bytes[w_pidx] <= {w_is_hex ? w_hex_val : 4'd0, 4'd0};
            end else begin
                r_pair_bytes[w_pidx] <= w_is_hex ? {r_hi_nib, w_hex_val} : {4'd0, r_hi_nib};
            end
        end
        if (i_cmd.end_line && !r_halted && w_line_err) begin
            r_out_item <= '{kind: thrl_pkg::KIND_ERROR, write_address: 13'd0,
                            write_data: 8'd0, line_number: w_line_num,
                            load_ok: 1'b0, last: 1'b1};
        end
        if (i_cmd.end_file) begin
            r_out_item <= '{kind: thrl_pkg::KIND_FINISH, write_address: 13'd0,
                            write_data: 8'd0, line_number: 16'd0,
                            load_ok: !r_halted, last: 1'b1};
        end
        if (i_cmd.emit) begin
            r_out_item <= '{kind: thrl_pkg::KIND_WRITE,
                            write_address: {1'b0, r_line_address} + 13'(w_emit_idx),
                            write_data: r_pair_bytes[w_emit_idx], line_number: 16'd0,
                            load_ok: 1'b0, last: o_sts.emit_last};
        end
    end

endmodule

// ----- rtl/text_hex_record_loader.sv -----
// ----------------------------------------------------------------------------
// text_hex_record_loader
// loads fixed-column hex object text into byte writes, outside a write drain one character a cycle
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_item) carries one text
//   character, an end of line or an end of file per transfer
//   output channel (o_out_valid / i_out_ready / o_out_item) carries byte
//   writes, a line format error or the load finished report; last marks the
//   final result caused by one input transfer
//   characters are accepted one per cycle outside a write drain, even while a
//   result waits in the output register
//   end of line on a good line whose first pair is present drains one write per
//   present pair from the pair store, one per cycle while the output register is free;
//   no input is taken during the drain
//   end of line and end of file need a free output register: a stalled
//   receiver holds them off, and characters keep flowing meanwhile
//   error and finish results appear the cycle after their transfer; the
//   first write of a drain goes through the sequencer state, then the output register
//   synchronous active-low reset clears the line state, sets the line count
//   to one and clears the halted flag; no clearing pass is needed
// ----------------------------------------------------------------------------
module text_hex_record_loader #(
    parameter int LINE_COUNT_BITS = thrl_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  thrl_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output thrl_pkg::t_out_item o_out_item
);

    // command and status between sequencer and datapath
    thrl_pkg::t_ctl_cmd w_cmd;
    thrl_pkg::t_ctl_sts w_sts;

    // sequencer: decides when an input transfer happens and paces the drain
    thrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_item.op),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: column checks, pair store, line counter, output register
    thrl_datapath #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_in_item.char_code),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // an error result always leaves the loader halted
    a_err_halts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == thrl_pkg::KIND_ERROR) |-> w_sts.halted)
        else $error("error result without halted state");

    // no input transfer during the write drain
    a_busy_no_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.busy |-> !o_in_ready)
        else $error("input ready during write drain");

    // a drain write is only issued into a free output register
    a_emit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("write issued over a waiting result");

    // reset leaves no result pending
    a_reset_clear : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

// ----- test/text_hex_record_loader_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_hex_record_loader_tb
// streams fixed-column hex object text into the loader and checks every
// byte write, line error and finish report against a cycle-free model of
// the loader kept in this bench; a short table of hand-made lines comes
// first, then random well-formed, blank-led and cut-short lines, then one
// broken line that halts the loader, followed by lines that must be ignored
// ----------------------------------------------------------------------------
module text_hex_record_loader_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 110;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int LINE_MAX      = 65535;
    localparam int DATA_CHARS    = 20;
    localparam int NO_TYPED      = -1;

    // a character that is neither a hex digit nor any of the fixed marks
    localparam logic [7:0] CH_NOT_HEX = 8'h67;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    // ways the closing line of the run gets broken
    typedef enum int {
        BRK_EMPTY,
        BRK_SHORT,
        BRK_PREFIX,
        BRK_DATA,
        BRK_PARITY,
        BRK_BAR
    } t_break;

    // receiver back-pressure patterns
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_DUTY
    } t_ready_mode;

    // one hand-made line: its text, the item that closes it and, for finish
    // reports, the load_ok value that is plain to see
    typedef struct {
        string      text;
        logic [1:0] term;
        int         finish_ok;
    } t_row;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    thrl_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    thrl_pkg::t_out_item out_item;

    text_hex_record_loader dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // loader model state, same reset values as the block
    // ------------------------------------------------------------------
    int unsigned ld_col     = 0;
    logic [11:0] ld_addr    = '0;
    logic [7:0]  ld_bytes [thrl_pkg::NUM_PAIRS];
    logic [9:0]  ld_present = '0;
    bit          ld_bad     = 1'b0;
    bit          ld_blank0  = 1'b0;
    bit          ld_odd     = 1'b0;
    int          ld_lines   = 1;
    bit          ld_halted  = 1'b0;

    // results caused by the last modeled item
    thrl_pkg::t_out_item step_out [thrl_pkg::NUM_PAIRS];

    // results still owed by the block, oldest first
    thrl_pkg::t_out_item pending_results [$];

    // text of the line being built for the random part
    logic [7:0]  rec_buf [$];

    int          fails        = 0;
    int          burst_left   = 0;
    int          random_items = 0;
    int unsigned ready_left   = 0;
    t_ready_mode ready_mode   = RDY_ALWAYS;

    t_row head_rows [9];
    t_row tail_rows [5];

    function automatic int hex_value(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch - "0");
        if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
        if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
        return -1;
    endfunction

    // random case for the letter digits
    function automatic logic [7:0] hex_char(input int v);
        logic [7:0] c;
        if (v < 10) begin
            c = thrl_pkg::CH_ZERO + v[7:0];
        end else if ($urandom_range(0, 1) != 0) begin
            c = "a" + v[7:0] - 8'd10;
        end else begin
            c = "A" + v[7:0] - 8'd10;
        end
        return c;
    endfunction

    function automatic thrl_pkg::t_in_item make_item(input logic [1:0] op,
            input logic [7:0] ch);
        thrl_pkg::t_in_item it;
        it.op        = op;
        it.char_code = ch;
        return it;
    endfunction

    function automatic thrl_pkg::t_out_item make_result(input logic [1:0] kind,
            input int addr, input int data, input int lnum, input logic ok,
            input logic last);
        thrl_pkg::t_out_item r;
        r.kind          = kind;
        r.write_address = addr[12:0];
        r.write_data    = data[7:0];
        r.line_number   = lnum[15:0];
        r.load_ok       = ok;
        r.last          = last;
        return r;
    endfunction

    function automatic void clear_line_state();
        ld_col     = 0;
        ld_addr    = '0;
        ld_present = '0;
        ld_bad     = 1'b0;
        ld_blank0  = 1'b0;
        ld_odd     = 1'b0;
    endfunction

    // one text character into the line state
    function automatic void feed_char(input logic [7:0] ch);
        int          d;
        int unsigned p;
        logic [3:0]  nib;
        d   = hex_value(ch);
        nib = (d < 0) ? 4'd0 : d[3:0];
        if (ld_col >= thrl_pkg::COL_SAT) return;
        if (ld_col == 0) begin
            ld_blank0 = (ch == thrl_pkg::CH_SPACE);
            if (ch != thrl_pkg::CH_ZERO) ld_bad = 1'b1;
        end else if (ld_col == 1) begin
            if (ch != thrl_pkg::CH_X) ld_bad = 1'b1;
        end else if (ld_col <= 4) begin
            // address digits, a non-hex one reads as zero
            if (d < 0) ld_bad = 1'b1;
            ld_addr = {ld_addr[7:0], nib};
        end else if (ld_col == 5) begin
            if (ch != thrl_pkg::CH_COLON) ld_bad = 1'b1;
        end else if (ld_col == 6) begin
            if (ch != thrl_pkg::CH_SPACE) ld_bad = 1'b1;
        end else if (ld_col <= thrl_pkg::COL_LAST_DATA) begin
            p = (ld_col - thrl_pkg::COL_DATA) >> 1;
            if (ch != thrl_pkg::CH_SPACE) begin
                ld_odd = ~ld_odd;
                if (d < 0) ld_bad = 1'b1;
            end
            if (((ld_col - thrl_pkg::COL_DATA) & 1) == 0) begin
                if (ch != thrl_pkg::CH_SPACE) ld_present[p] = 1'b1;
                ld_bytes[p] = {nib, 4'h0};
            end else if (d >= 0) begin
                ld_bytes[p] = ld_bytes[p] | {4'h0, nib};
            end else begin
                // blank or junk second digit makes the first digit the low nibble
                ld_bytes[p] = ld_bytes[p] >> 4;
            end
        end else if (ld_col == thrl_pkg::COL_PARITY_ONLY) begin
            if (ch != thrl_pkg::CH_SPACE) ld_odd = ~ld_odd;
        end else begin
            if (ch != thrl_pkg::CH_BAR) ld_bad = 1'b1;
        end
        ld_col++;
    endfunction

    // models one accepted input item, leaves its results in step_out
    function automatic int loader_step(input thrl_pkg::t_in_item it);
        int n;
        n = 0;
        case (it.op)
            thrl_pkg::OP_CHAR: begin
                if (!ld_halted) feed_char(it.char_code);
            end
            thrl_pkg::OP_EOL: begin
                if (!ld_halted) begin
                    if (!ld_blank0 && (ld_bad || ld_col < thrl_pkg::COL_SAT || ld_odd)) begin
                        step_out[0] = make_result(thrl_pkg::KIND_ERROR, 0, 0, ld_lines,
                            1'b0, 1'b0);
                        n = 1;
                        ld_halted = 1'b1;
                    end else if (ld_present[0]) begin
                        for (int p = 0; p < thrl_pkg::NUM_PAIRS; p++) begin
                            if (ld_present[p]) begin
                                step_out[n] = make_result(thrl_pkg::KIND_WRITE,
                                    int'(ld_addr) + p, int'(ld_bytes[p]), 0, 1'b0, 1'b0);
                                n++;
                            end
                        end
                    end
                    if (ld_lines < LINE_MAX) ld_lines++;
                    clear_line_state();
                end
            end
            thrl_pkg::OP_EOF: begin
                step_out[0] = make_result(thrl_pkg::KIND_FINISH, 0, 0, 0, !ld_halted, 1'b0);
                n = 1;
                clear_line_state();
            end
            default: ;
        endcase
        if (n > 0) step_out[n - 1].last = 1'b1;
        return n;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
            input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    function automatic void check_result(input thrl_pkg::t_out_item got);
        thrl_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                $time, got);
            fails++;
            return;
        end
        want = pending_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(got.kind));
        check_field("write_address", 16'(want.write_address), 16'(got.write_address));
        check_field("write_data", 16'(want.write_data), 16'(got.write_data));
        check_field("line_number", want.line_number, got.line_number);
        check_field("load_ok", 16'(want.load_ok), 16'(got.load_ok));
        check_field("last", 16'(want.last), 16'(got.last));
    endfunction

    // a well-formed record: random address, the given number of pairs with
    // the odd blank among them, column 27 filled in to keep the count even
    function automatic void build_record(input int pairs);
        bit         odd;
        logic [7:0] ch;
        rec_buf.delete();
        odd = 1'b0;
        rec_buf.push_back(thrl_pkg::CH_ZERO);
        rec_buf.push_back(thrl_pkg::CH_X);
        repeat (3) rec_buf.push_back(hex_char($urandom_range(0, 15)));
        rec_buf.push_back(thrl_pkg::CH_COLON);
        rec_buf.push_back(thrl_pkg::CH_SPACE);
        for (int c = 0; c < DATA_CHARS; c++) begin
            if (c < 2 * pairs && $urandom_range(0, 9) != 0) begin
                ch = hex_char($urandom_range(0, 15));
            end else begin
                ch = thrl_pkg::CH_SPACE;
            end
            if (ch != thrl_pkg::CH_SPACE) odd = ~odd;
            rec_buf.push_back(ch);
        end
        ch = thrl_pkg::CH_SPACE;
        if (odd) begin
            ch = 8'($urandom_range(0, 255));
            if (ch == thrl_pkg::CH_SPACE) ch = CH_TILDE;
        end
        rec_buf.push_back(ch);
        rec_buf.push_back(thrl_pkg::CH_BAR);
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of random length with random gaps in between; the
    // model is stepped at the edge where the transfer happens
    // ------------------------------------------------------------------
    task automatic send_item(input thrl_pkg::t_in_item it, input int finish_ok);
        int n;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            // some bursts follow the last one with no gap at all
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        n = loader_step(it);
        if (finish_ok != NO_TYPED) begin
            pending_results.push_back(make_result(thrl_pkg::KIND_FINISH, 0, 0, 0,
                finish_ok[0], 1'b1));
        end else begin
            for (int i = 0; i < n; i++) pending_results.push_back(step_out[i]);
        end
    endtask

    task automatic send_row(input t_row row);
        for (int i = 0; i < row.text.len(); i++) begin
            send_item(make_item(thrl_pkg::OP_CHAR, row.text[i]), NO_TYPED);
        end
        send_item(make_item(row.term, 8'($urandom_range(0, 255))), row.finish_ok);
    endtask

    // the built line with a stray no-op now and then, then its closing item
    task automatic send_record(input logic [1:0] term);
        foreach (rec_buf[i]) begin
            if ($urandom_range(0, 29) == 0) begin
                send_item(make_item(thrl_pkg::OP_NOP, 8'($urandom_range(0, 255))), NO_TYPED);
            end
            send_item(make_item(thrl_pkg::OP_CHAR, rec_buf[i]), NO_TYPED);
        end
        send_item(make_item(term, 8'($urandom_range(0, 255))), NO_TYPED);
        random_items += rec_buf.size() + 1;
    endtask

    // hold the sender off until every owed result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // receiver: checks each transfer and picks a new stall pattern whenever
    // its ready_left counter runs out
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) check_result(out_item);
        if (ready_left == 0) begin
            ready_left = $urandom_range(20, 200);
            ready_mode = t_ready_mode'($urandom_range(0, 3));
        end
        ready_left--;
        case (ready_mode)
            RDY_ALWAYS: out_ready <= 1'b1;
            RDY_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
            RDY_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
            default:    out_ready <= ((ready_left % 16) < 4);
        endcase
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int     pick;
        int     cut;
        bit     mid_drained;
        t_break brk;
        logic [7:0] ch;

        mid_drained = 1'b0;

        head_rows = '{
            // every pair filled, mixed case, lowest address
            '{"0x000: 00ffFF7aA09fF9100180 |", thrl_pkg::OP_EOL, NO_TYPED},
            // highest address, writes run past 4095
            '{"0xFfF: 0123456789abcdefABCD |", thrl_pkg::OP_EOL, NO_TYPED},
            // blank second digit, column 27 evens out the count
            '{"0x020: 123                 z|", thrl_pkg::OP_EOL, NO_TYPED},
            // characters after the bar
            '{"0x040: ab                   |junk~", thrl_pkg::OP_EOL, NO_TYPED},
            // blank-led short line with junk digits and an 0xff byte
            '{" x1g2:?Gz1 45\377", thrl_pkg::OP_EOL, NO_TYPED},
            // blank-led line with column 7 blank, no writes
            '{"        12", thrl_pkg::OP_EOL, NO_TYPED},
            // operation code 3
            '{"", thrl_pkg::OP_NOP, NO_TYPED},
            // end of file drops an open line
            '{"0x050: 11", thrl_pkg::OP_EOF, 1},
            '{"", thrl_pkg::OP_EOF, 1}
        };

        // after the loader has halted only finish reports come out
        tail_rows = '{
            '{"0x000: 00ffFF7aA09fF9100180 |", thrl_pkg::OP_EOL, NO_TYPED},
            '{"", thrl_pkg::OP_NOP, NO_TYPED},
            '{"", thrl_pkg::OP_EOF, 0},
            '{" 0x", thrl_pkg::OP_EOL, NO_TYPED},
            '{"", thrl_pkg::OP_EOF, 0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (head_rows[i]) send_row(head_rows[i]);
        drain_results();

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                build_record($urandom_range(0, thrl_pkg::NUM_PAIRS));
                // sometimes junk after the bar
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        rec_buf.push_back(8'($urandom_range(0, 255)));
                    end
                end
                send_record(thrl_pkg::OP_EOL);
            end else if (pick < 85) begin
                // blank-led line of any bytes, hex digits and extremes mixed in
                rec_buf.delete();
                rec_buf.push_back(thrl_pkg::CH_SPACE);
                repeat ($urandom_range(0, 34)) begin
                    case ($urandom_range(0, 7))
                        0:       ch = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                        1, 2, 3: ch = hex_char($urandom_range(0, 15));
                        default: ch = 8'($urandom_range(0, 255));
                    endcase
                    rec_buf.push_back(ch);
                end
                send_record(thrl_pkg::OP_EOL);
            end else if (pick < 93) begin
                // open line cut short by end of file
                build_record($urandom_range(0, thrl_pkg::NUM_PAIRS));
                cut = $urandom_range(0, thrl_pkg::COL_BAR);
                while (rec_buf.size() > cut) void'(rec_buf.pop_back());
                send_record(thrl_pkg::OP_EOF);
            end else begin
                send_item(make_item(thrl_pkg::OP_NOP, 8'($urandom_range(0, 255))), NO_TYPED);
                random_items++;
            end
            if (!mid_drained && random_items >= RANDOM_ITEMS / 2) begin
                drain_results();
                mid_drained = 1'b1;
            end
        end
        drain_results();

        // one broken line, the loader halts on it for good
        build_record($urandom_range(1, thrl_pkg::NUM_PAIRS));
        brk = t_break'($urandom_range(0, 5));
        case (brk)
            BRK_EMPTY:  rec_buf.delete();
            BRK_SHORT: begin
                cut = $urandom_range(1, thrl_pkg::COL_BAR);
                while (rec_buf.size() > cut) void'(rec_buf.pop_back());
            end
            BRK_PREFIX: rec_buf[$urandom_range(0, 6)] = CH_NOT_HEX;
            BRK_DATA: begin
                rec_buf[$urandom_range(thrl_pkg::COL_DATA, thrl_pkg::COL_LAST_DATA)] =
                    CH_NOT_HEX;
            end
            BRK_PARITY: begin
                rec_buf[thrl_pkg::COL_PARITY_ONLY] =
                    (rec_buf[thrl_pkg::COL_PARITY_ONLY] == thrl_pkg::CH_SPACE) ?
                    CH_NOT_HEX : thrl_pkg::CH_SPACE;
            end
            default: begin
                ch = 8'($urandom_range(0, 255));
                if (ch == thrl_pkg::CH_BAR) ch = CH_TILDE;
                rec_buf[thrl_pkg::COL_BAR] = ch;
            end
        endcase
        send_record(thrl_pkg::OP_EOL);

        foreach (tail_rows[i]) send_row(tail_rows[i]);

        // wait out every owed result, then a quiet spell for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fails == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/thrl_pkg.sv
rtl/thrl_ctrl.sv
rtl/thrl_datapath.sv
rtl/text_hex_record_loader.sv
test/text_hex_record_loader_tb.sv
